// ===== src/fxa_pkg.sv =====
// Shared types and constants for the fixed-point ALU.
package fxa_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int FIFO_DEPTH_DEF = 2;

   typedef enum logic [3:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_GT      = 4'd4,
      OP_LT      = 4'd5,
      OP_GE      = 4'd6,
      OP_LE      = 4'd7,
      OP_EQ      = 4'd8,
      OP_NE      = 4'd9,
      OP_MIN     = 4'd10,
      OP_MAX     = 4'd11,
      OP_INC     = 4'd12,
      OP_DEC     = 4'd13,
      OP_TOINT   = 4'd14,
      OP_FROMINT = 4'd15
   } fxa_op_type;

   typedef enum logic [1:0] {
      KIND_SIMPLE = 2'd0,
      KIND_MUL    = 2'd1,
      KIND_DIV    = 2'd2
   } fxa_kind_type;

   typedef struct packed {
      fxa_kind_type kind;
      logic         neg;
      logic         cmp;
      logic         dz;
      logic         sat;
   } fxa_ctrl_type;

   localparam int CTRL_W = $bits(fxa_ctrl_type);

endpackage

// ===== src/fxa_front.sv =====
// Front end: decodes an operation, finishes the simple ones and prepares magnitudes.
module fxa_front import fxa_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic [3:0]                   req_func,
   input  logic signed [DATA_WIDTH-1:0] req_operand_a,
   input  logic signed [DATA_WIDTH-1:0] req_operand_b,
   output fxa_ctrl_type                 item_ctrl,
   output logic [DATA_WIDTH-1:0]        item_res,
   output logic [DATA_WIDTH-1:0]        item_mag_a,
   output logic [DATA_WIDTH-1:0]        item_mag_b
);

   localparam int DW = DATA_WIDTH;
   localparam logic [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};

   fxa_op_type      op;
   logic [DW-1:0]   a, b, opb, sum, clamp_a, to_int, from_int;
   logic            sub, same, ovf, lt, eq, fi_ovf;
   logic [FRAC_BITS:0] a_top;

   assign op  = fxa_op_type'(req_func);
   assign a   = req_operand_a;
   assign b   = req_operand_b;

   // Increment and decrement share the add/subtract path with a unit operand.
   assign sub  = (op == OP_SUB) || (op == OP_DEC);
   assign opb  = ((op == OP_INC) || (op == OP_DEC)) ? DW'(1) : b;
   assign sum  = sub ? (a - opb) : (a + opb);
   assign same = (a[DW-1] == opb[DW-1]);
   assign ovf  = (sub ? !same : same) && (sum[DW-1] != a[DW-1]);
   assign clamp_a = a[DW-1] ? MIN_VAL : MAX_VAL;

   assign lt = $signed(a) < $signed(b);
   assign eq = (a == b);

   assign to_int = DW'($signed(a) >>> FRAC_BITS);

   // The shift from integer overflows unless the bits shifted out match the sign.
   assign a_top    = a[DW-1 -: FRAC_BITS+1];
   assign fi_ovf   = !((&a_top) || !(|a_top));
   assign from_int = a << FRAC_BITS;

   assign item_mag_a = a[DW-1] ? (~a + DW'(1)) : a;
   assign item_mag_b = b[DW-1] ? (~b + DW'(1)) : b;

   always_comb begin
      item_ctrl.kind = KIND_SIMPLE;
      item_ctrl.neg  = a[DW-1] ^ b[DW-1];
      item_ctrl.cmp  = 1'b0;
      item_ctrl.dz   = 1'b0;
      item_ctrl.sat  = 1'b0;
      item_res       = '0;
      unique case (op)
         OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
            item_res      = ovf ? clamp_a : sum;
            item_ctrl.sat = ovf;
         end
         OP_MUL: item_ctrl.kind = KIND_MUL;
         OP_DIV: begin
            item_ctrl.kind = (b == '0) ? KIND_SIMPLE : KIND_DIV;
            item_ctrl.dz   = (b == '0);
         end
         OP_GT: item_ctrl.cmp = !lt && !eq;
         OP_LT: item_ctrl.cmp = lt;
         OP_GE: item_ctrl.cmp = !lt;
         OP_LE: item_ctrl.cmp = lt || eq;
         OP_EQ: item_ctrl.cmp = eq;
         OP_NE: item_ctrl.cmp = !eq;
         OP_MIN: item_res = (lt || eq) ? a : b;
         OP_MAX: item_res = !lt ? a : b;
         OP_TOINT: item_res = to_int;
         OP_FROMINT: begin
            item_res      = fi_ovf ? clamp_a : from_int;
            item_ctrl.sat = fi_ovf;
         end
      endcase
   end

endmodule

// ===== src/fxa_fifo.sv =====
// Short queue between the front end and the arithmetic pipeline.
module fxa_fifo import fxa_pkg::*; #(
   parameter int WIDTH = CTRL_W,
   parameter int DEPTH = FIFO_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   // DEPTH is a power of two so the pointers wrap on their own.
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (PW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   assign wr_in    = do_push ? wr_ff + PW'(1) : wr_ff;
   assign rd_in    = do_pop ? rd_ff + PW'(1) : rd_ff;
   assign count_in = count_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== src/fxa_back.sv =====
// Arithmetic pipeline: split multiplier, one-bit-per-stage divider, rounding and clamping.
module fxa_back import fxa_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  fxa_ctrl_type                 in_ctrl,
   input  logic [DATA_WIDTH-1:0]        in_res,
   input  logic [DATA_WIDTH-1:0]        in_mag_a,
   input  logic [DATA_WIDTH-1:0]        in_mag_b,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_result_value,
   output logic                         rsp_compare_true,
   output logic                         rsp_divide_by_zero,
   output logic                         rsp_saturated
);

   localparam int DW  = DATA_WIDTH;
   localparam int QW  = DATA_WIDTH + FRAC_BITS;
   localparam int PWD = 2 * DATA_WIDTH;
   localparam int MW  = (PWD > QW + 1) ? PWD : QW + 1;
   localparam int HL  = DATA_WIDTH / 2;
   localparam int HH  = DATA_WIDTH - HL;
   localparam int LATENCY = QW + 1;

   // One restoring division step: returns the new remainder and the shifted word.
   function automatic logic [DW+QW-1:0] div_step(input logic [DW-1:0] r,
                                                 input logic [QW-1:0] w,
                                                 input logic [DW-1:0] d);
      logic [DW:0] t;
      logic [DW:0] diff;
      logic        ge;
      t    = {r, w[QW-1]};
      diff = t - {1'b0, d};
      ge   = (t >= {1'b0, d});
      div_step = {(ge ? diff[DW-1:0] : t[DW-1:0]), w[QW-2:0], ge};
   endfunction

   // Signs a magnitude and clamps it to the signed range; the top bit is the clamp flag.
   function automatic logic [DW:0] sat_encode(input logic neg, input logic [MW-1:0] mag);
      logic [MW-1:0] lim;
      logic          sat;
      logic [DW-1:0] val;
      lim = MW'(1) << (DW - 1);
      if (!neg) begin
         lim = lim - MW'(1);
      end
      sat = (mag > lim);
      if (sat) begin
         val = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
         val = neg ? (~mag[DW-1:0] + DW'(1)) : mag[DW-1:0];
      end
      sat_encode = {sat, val};
   endfunction

   logic          v_ff    [QW];
   fxa_ctrl_type  c_ff    [QW];
   logic [DW-1:0] res_ff  [QW];
   logic [DW-1:0] d_ff    [QW];
   logic [DW-1:0] rem_ff  [QW];
   logic [QW-1:0] work_ff [QW];

   logic [2*HL-1:0]    p00_ff;
   logic [HL+HH-1:0]   p01_ff, p10_ff;
   logic [2*HH-1:0]    p11_ff;
   logic [PWD-1:0]     prod;
   logic [MW-1:0]      mul_mag;
   logic [DW:0]        mul_enc;
   logic [DW+QW-1:0]   step0;
   logic [MW-1:0]      q_round;
   logic               rnd;
   logic [DW:0]        div_enc;
   fxa_ctrl_type       last_c;
   fxa_ctrl_type       c1_in;
   logic [DW-1:0]      res1_in;

   logic               rsp_valid_ff;
   logic [DW-1:0]      rsp_res_ff;
   logic               rsp_cmp_ff, rsp_dz_ff, rsp_sat_ff;

   assign step0 = div_step('0, {in_mag_a, {FRAC_BITS{1'b0}}}, in_mag_b);

   // The product is rebuilt from the four half-width partial products registered beside stage zero.
   assign prod = PWD'(p00_ff)
               + ((PWD'(p01_ff) + PWD'(p10_ff)) << HL)
               + (PWD'(p11_ff) << (2 * HL))
               + (PWD'(1) << (FRAC_BITS - 1));
   assign mul_mag = MW'(prod >> FRAC_BITS);
   assign mul_enc = sat_encode(c_ff[0].neg, mul_mag);

   // A multiply beat picks up its value and clamp flag on the way into stage one.
   always_comb begin
      c1_in   = c_ff[0];
      res1_in = res_ff[0];
      if (c_ff[0].kind == KIND_MUL) begin
         res1_in   = mul_enc[DW-1:0];
         c1_in.sat = mul_enc[DW];
      end
   end

   // Round half away from zero on the final remainder.
   assign last_c  = c_ff[QW-1];
   assign rnd     = (rem_ff[QW-1] >= (d_ff[QW-1] - rem_ff[QW-1]));
   assign q_round = MW'(work_ff[QW-1]) + MW'(rnd);
   assign div_enc = sat_encode(last_c.neg, q_round);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < QW; s++) begin
            v_ff[s] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < QW; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
         rsp_valid_ff <= v_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      c_ff[0]    <= in_ctrl;
      res_ff[0]  <= in_res;
      d_ff[0]    <= in_mag_b;
      rem_ff[0]  <= step0[DW+QW-1:QW];
      work_ff[0] <= step0[QW-1:0];
      p00_ff     <= in_mag_a[HL-1:0] * in_mag_b[HL-1:0];
      p01_ff     <= in_mag_a[HL-1:0] * in_mag_b[DW-1:HL];
      p10_ff     <= in_mag_a[DW-1:HL] * in_mag_b[HL-1:0];
      p11_ff     <= in_mag_a[DW-1:HL] * in_mag_b[DW-1:HL];
      c_ff[1]    <= c1_in;
      res_ff[1]  <= res1_in;
      for (int s = 2; s < QW; s++) begin
         c_ff[s]    <= c_ff[s-1];
         res_ff[s]  <= res_ff[s-1];
      end
      for (int s = 1; s < QW; s++) begin
         d_ff[s]    <= d_ff[s-1];
         {rem_ff[s], work_ff[s]} <= div_step(rem_ff[s-1], work_ff[s-1], d_ff[s-1]);
      end
      rsp_cmp_ff <= last_c.cmp;
      rsp_dz_ff  <= last_c.dz;
      if (last_c.kind == KIND_DIV) begin
         rsp_res_ff <= div_enc[DW-1:0];
         rsp_sat_ff <= div_enc[DW];
      end else begin
         rsp_res_ff <= res_ff[QW-1];
         rsp_sat_ff <= last_c.sat;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = rsp_res_ff;
   assign rsp_compare_true   = rsp_cmp_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;
   assign rsp_saturated      = rsp_sat_ff;

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##LATENCY rsp_valid)
      else $error("result beat did not leave at the fixed latency");

   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_compare_true) |-> (rsp_result_value == '0) && !rsp_saturated)
      else $error("compare beat carries a value or clamp flag");

   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_result_value == '0) && !rsp_saturated
                                           && !rsp_compare_true)
      else $error("divide by zero beat is not zero");

endmodule

// ===== src/fixed_point_q24_8_alu_top.sv =====
// Top level of the signed Q24.8 fixed-point ALU.
//
// Usage: drive req_func, req_operand_a and req_operand_b and raise start; the
// beat is taken at a rising edge where start is high and busy is low. The
// front end decodes the operation and finishes add, sub, compares, min, max,
// inc, dec, toint and fromint at once; every beat then passes a two-entry
// queue into the arithmetic pipeline, which holds a split multiplier and a
// divider that produces one quotient bit per stage.
// Every operation takes the same path, so results leave in order, one clock
// cycle wide and marked by rsp_valid; each is registered in the queue, in every
// stage of the arithmetic pipeline and in the result register, at the default
// Q24.8 size as at any other. The depth of that path is set by the divider stages.
// A new beat may be started every cycle; the pipeline never stops, so busy
// stays low in normal use and only guards the queue.
// The result receiver cannot stall: each beat is presented for one cycle.
// A synchronous reset empties the queue and drops every beat in flight.
module fixed_point_q24_8_alu_top import fxa_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [3:0]                   req_func,
   input  logic signed [DATA_WIDTH-1:0] req_operand_a,
   input  logic signed [DATA_WIDTH-1:0] req_operand_b,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_result_value,
   output logic                         rsp_compare_true,
   output logic                         rsp_divide_by_zero,
   output logic                         rsp_saturated
);

   localparam int DW     = DATA_WIDTH;
   localparam int ITEM_W = CTRL_W + 3 * DATA_WIDTH;

   fxa_ctrl_type    f_ctrl, b_ctrl;
   logic [DW-1:0]   f_res, f_mag_a, f_mag_b, b_res, b_mag_a, b_mag_b;
   logic [ITEM_W-1:0] q_in, q_out;
   logic            q_full, q_empty;

   fxa_front #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .req_func     (req_func),
      .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .item_ctrl    (f_ctrl),
      .item_res     (f_res),
      .item_mag_a   (f_mag_a),
      .item_mag_b   (f_mag_b)
   );

   assign q_in = {f_ctrl, f_res, f_mag_a, f_mag_b};

   fxa_fifo #(
      .WIDTH(ITEM_W),
      .DEPTH(FIFO_DEPTH_DEF)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (start),
      .push_data(q_in),
      .pop      (!q_empty),
      .pop_data (q_out),
      .full     (q_full),
      .empty    (q_empty)
   );

   assign busy = q_full;
   assign {b_ctrl, b_res, b_mag_a, b_mag_b} = q_out;

   fxa_back #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (!q_empty),
      .in_ctrl           (b_ctrl),
      .in_res            (b_res),
      .in_mag_a          (b_mag_a),
      .in_mag_b          (b_mag_b),
      .rsp_valid         (rsp_valid),
      .rsp_result_value  (rsp_result_value),
      .rsp_compare_true  (rsp_compare_true),
      .rsp_divide_by_zero(rsp_divide_by_zero),
      .rsp_saturated     (rsp_saturated)
   );

endmodule
